// ===== rtl/rct_pkg.sv =====
// ----------------------------------------------------------------------------
// rct_pkg
// Shared types and constants for the replay counter table.
// ----------------------------------------------------------------------------
`default_nettype none

package rct_pkg;

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned CTR_W  = 32;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned ENTRY_W = ADDR_W + CTR_W;

  typedef enum logic [1:0] {
    OUT_UPDATED = 2'd0,
    OUT_NEW     = 2'd1,
    OUT_EVICTED = 2'd2,
    OUT_REPLAY  = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/rct_mem.sv =====
// ----------------------------------------------------------------------------
// rct_mem
// Peer entry memory: address and last counter, one write and one
// registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rct_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IW    = 4
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [IW-1:0]               waddr,
  input  wire logic [rct_pkg::ENTRY_W-1:0] wdata,
  input  wire logic [IW-1:0]               raddr,
  output logic      [rct_pkg::ENTRY_W-1:0] rdata
);

  logic [rct_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/replay_counter_table.sv =====
// ----------------------------------------------------------------------------
// replay_counter_table
// Per-peer frame counter replay check over a table of PEERS entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_sender_address / in_frame_counter with start high; the
//   transfer happens at the edge where start is high and busy is low.
//   Output: one result per frame, shown for exactly one cycle with out_valid
//   high (out_accepted, out_slot_index, out_outcome). The receiver cannot
//   stall; the result must be taken in that cycle.
// Scan:
//   The table memory is read one entry per cycle from entry 0 upward, through
//   its registered read port. A frame whose address matches entry m gives
//   its result once entry m has been checked; otherwise once the last entry
//   has been checked. busy drops the cycle after the result, so a new frame
//   is taken only after the previous result. The scan through the single
//   memory read port sets this pace.
// Reset:
//   rst_n low clears every valid mark and returns the block to idle; no
//   memory clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module replay_counter_table #(
  parameter int unsigned PEERS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [rct_pkg::ADDR_W-1:0]  in_sender_address,
  input  wire logic [rct_pkg::CTR_W-1:0]   in_frame_counter,
  output logic                             out_valid,
  output logic                             out_accepted,
  output logic      [rct_pkg::SLOT_W-1:0]  out_slot_index,
  output logic      [1:0]                  out_outcome
);

  localparam int unsigned IW = (PEERS > 1) ? $clog2(PEERS) : 1;

  rct_pkg::state_t   state_r, state_nxt;
  logic [rct_pkg::ADDR_W-1:0] addr_r;
  logic [rct_pkg::CTR_W-1:0]  ctr_r;
  logic [IW:0]       cnt_r;
  logic              rd_vld_r;
  logic [IW-1:0]     chk_idx_r;
  logic              valid_r [PEERS];
  logic              have_free_r;
  logic [IW-1:0]     free_idx_r;
  logic [rct_pkg::CTR_W-1:0]  min_ctr_r;
  logic [IW-1:0]     min_idx_r;
  logic              wr_en_r;
  logic              acc_r;
  logic [IW-1:0]     slot_r;
  rct_pkg::outcome_t outcome_r;

  logic                        accept;
  logic                        scan_en;
  logic                        mem_we;
  logic [rct_pkg::ENTRY_W-1:0] rdata;
  logic [rct_pkg::ADDR_W-1:0]  rd_addr;
  logic [rct_pkg::CTR_W-1:0]   rd_ctr;
  logic                        ent_vld;
  logic                        hit;
  logic                        last;
  logic                        scan_end;
  logic                        have_free_c;
  logic [IW-1:0]               free_idx_c;
  logic                        take_min;
  logic [rct_pkg::CTR_W-1:0]   min_ctr_c;
  logic [IW-1:0]               min_idx_c;
  logic                        dec_acc;
  logic                        dec_we;
  logic [IW-1:0]               dec_slot;
  rct_pkg::outcome_t           dec_outcome;
  logic [IW+3:0]               slot_ext;

  // entry memory
  rct_mem #(
    .DEPTH (PEERS),
    .IW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot_r),
    .wdata ({addr_r, ctr_r}),
    .raddr (cnt_r[IW-1:0]),
    .rdata (rdata)
  );

  assign rd_addr = rdata[rct_pkg::ENTRY_W-1:rct_pkg::CTR_W];
  assign rd_ctr  = rdata[rct_pkg::CTR_W-1:0];
  assign accept  = start && !busy;

  // entry check
  always_comb begin
    ent_vld     = valid_r[chk_idx_r];
    hit         = ent_vld && (rd_addr == addr_r);
    last        = (chk_idx_r == IW'(PEERS - 1));
    scan_end    = rd_vld_r && (hit || last);
    have_free_c = have_free_r || !ent_vld;
    free_idx_c  = (!have_free_r && !ent_vld) ? chk_idx_r : free_idx_r;
    take_min    = (chk_idx_r == '0) || (rd_ctr < min_ctr_r);
    min_ctr_c   = take_min ? rd_ctr : min_ctr_r;
    min_idx_c   = take_min ? chk_idx_r : min_idx_r;
    if (hit) begin
      dec_slot = chk_idx_r;
      if (ctr_r > rd_ctr) begin
        dec_acc     = 1'b1;
        dec_we      = 1'b1;
        dec_outcome = rct_pkg::OUT_UPDATED;
      end else begin
        dec_acc     = 1'b0;
        dec_we      = 1'b0;
        dec_outcome = rct_pkg::OUT_REPLAY;
      end
    end else if (have_free_c) begin
      dec_slot    = free_idx_c;
      dec_acc     = 1'b1;
      dec_we      = 1'b1;
      dec_outcome = rct_pkg::OUT_NEW;
    end else begin
      dec_slot    = min_idx_c;
      dec_acc     = 1'b1;
      dec_we      = 1'b1;
      dec_outcome = rct_pkg::OUT_EVICTED;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rct_pkg::ST_IDLE: if (start) state_nxt = rct_pkg::ST_SCAN;
      rct_pkg::ST_SCAN: if (scan_end) state_nxt = rct_pkg::ST_DONE;
      rct_pkg::ST_DONE: state_nxt = rct_pkg::ST_IDLE;
      default:          state_nxt = rct_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    scan_en   = 1'b0;
    mem_we    = 1'b0;
    case (state_r)
      rct_pkg::ST_IDLE: busy = 1'b0;
      rct_pkg::ST_SCAN: scan_en = 1'b1;
      rct_pkg::ST_DONE: begin
        out_valid = 1'b1;
        mem_we    = wr_en_r;
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rct_pkg::ST_IDLE;
      rd_vld_r <= 1'b0;
      for (int i = 0; i < PEERS; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= scan_en && !scan_end && (cnt_r < (IW+1)'(PEERS));
      if (mem_we) begin
        valid_r[slot_r] <= 1'b1;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r      <= in_sender_address;
      ctr_r       <= in_frame_counter;
      cnt_r       <= '0;
      have_free_r <= 1'b0;
    end else if (scan_en) begin
      cnt_r     <= cnt_r + 1'b1;
      chk_idx_r <= cnt_r[IW-1:0];
      if (rd_vld_r) begin
        have_free_r <= have_free_c;
        free_idx_r  <= free_idx_c;
        min_ctr_r   <= min_ctr_c;
        min_idx_r   <= min_idx_c;
      end
      if (scan_end) begin
        wr_en_r   <= dec_we;
        acc_r     <= dec_acc;
        slot_r    <= dec_slot;
        outcome_r <= dec_outcome;
      end
    end
  end

  assign slot_ext       = {4'b0000, slot_r};
  assign out_slot_index = slot_ext[rct_pkg::SLOT_W-1:0];
  assign out_accepted   = acc_r;
  assign out_outcome    = outcome_r;

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after input transfer");

  a_replay_rejects: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome == rct_pkg::OUT_REPLAY) |-> !out_accepted)
    else $error("replay result marked accepted");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_write_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> out_valid && out_accepted)
    else $error("table write without accepted result");

endmodule

`default_nettype wire
